/* hdl/mme_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mme_pkg
// Shared widths and defaults for the modular exponentiation pipeline.
// ---------------------------------------------------------------------------
package mme_pkg;

    localparam int BASE_BITS     = 64;  // base field width
    localparam int EXP_FIELD     = 64;  // exponent field width
    localparam int MOD_FIELD     = 32;  // modulus and result field width
    localparam int EXP_BITS_DEF  = 64;  // exponent bits scanned
    localparam int MOD_BITS_DEF  = 32;  // modulus bits used

endpackage

/* hdl/mme_modmul.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mme_modmul
// Pipelined interleaved modular multiplier: one multiplier bit per stage.
// ---------------------------------------------------------------------------
module mme_modmul
    import mme_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int SIDE_W   = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [MOD_BITS-1:0] in_x,
    input  logic [MOD_BITS-1:0] in_y,
    input  logic [MOD_BITS-1:0] in_m,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [MOD_BITS-1:0] out_p,
    output logic [MOD_BITS-1:0] out_m,
    output logic [SIDE_W-1:0]   out_side
);

    logic                v_reg    [0:MOD_BITS-1];
    logic [MOD_BITS-1:0] x_reg    [0:MOD_BITS-1];
    logic [MOD_BITS-1:0] y_reg    [0:MOD_BITS-1];
    logic [MOD_BITS-1:0] r_reg    [0:MOD_BITS-1];
    logic [MOD_BITS-1:0] m_reg    [0:MOD_BITS-1];
    logic [SIDE_W-1:0]   side_reg [0:MOD_BITS-1];

    genvar k;
    generate
        for (k = 0; k < MOD_BITS; k++)
        begin : g_stage
            logic                a_v;
            logic [MOD_BITS-1:0] a_x;
            logic [MOD_BITS-1:0] a_y;
            logic [MOD_BITS-1:0] a_r;
            logic [MOD_BITS-1:0] a_m;
            logic [SIDE_W-1:0]   a_side;
            logic [MOD_BITS:0]   dbl;
            logic [MOD_BITS:0]   dbl_red;
            logic [MOD_BITS:0]   sum;
            logic [MOD_BITS:0]   sum_red;
            logic [MOD_BITS-1:0] r_next;

            if (k == 0)
            begin : g_in
                assign a_v    = in_valid;
                assign a_x    = in_x;
                assign a_y    = in_y;
                assign a_r    = '0;
                assign a_m    = in_m;
                assign a_side = in_side;
            end
            else
            begin : g_chain
                assign a_v    = v_reg[k-1];
                assign a_x    = x_reg[k-1];
                assign a_y    = y_reg[k-1];
                assign a_r    = r_reg[k-1];
                assign a_m    = m_reg[k-1];
                assign a_side = side_reg[k-1];
            end

            // r = 2r mod m, then r = r + (y bit ? x : 0) mod m
            always_comb
            begin
                dbl = {a_r, 1'b0};
                if (dbl >= {1'b0, a_m})
                    dbl_red = dbl - {1'b0, a_m};
                else
                    dbl_red = dbl;
                sum = dbl_red + (a_y[MOD_BITS-1] ? {1'b0, a_x} : '0);
                if (sum >= {1'b0, a_m})
                    sum_red = sum - {1'b0, a_m};
                else
                    sum_red = sum;
                r_next = sum_red[MOD_BITS-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else
                    v_reg[k] <= a_v;
            end

            always_ff @(posedge clk)
            begin
                x_reg[k]    <= a_x;
                y_reg[k]    <= {a_y[MOD_BITS-2:0], 1'b0};
                r_reg[k]    <= r_next;
                m_reg[k]    <= a_m;
                side_reg[k] <= a_side;
            end
        end
    endgenerate

    assign out_valid = v_reg[MOD_BITS-1];
    assign out_p     = r_reg[MOD_BITS-1];
    assign out_m     = m_reg[MOD_BITS-1];
    assign out_side  = side_reg[MOD_BITS-1];

endmodule

/* hdl/modular_exponentiation_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_exponentiation_top
// base^exponent mod modulus, fully unrolled square-and-multiply pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low. busy is always
//   low: the pipeline takes a new job every cycle.
//   base, exponent and modulus are sampled at that edge. Exponent bits at
//   and above EXP_BITS and modulus bits at and above MOD_BITS are ignored.
//   The answer shows on result for exactly one cycle with done high.
// Stages: input register, one base reduction bit per stage, then for each
//   exponent bit a square and a multiply, each a MOD_BITS-stage
//   bit-serial modular multiplier, then the output register.
// Throughput: one transaction per cycle; every multiplier stage is a single
//   interleaved step (double, add, two conditional subtracts).
// Reset clears every valid bit; jobs in flight are dropped.
// The receiver cannot stall: done is a one-cycle strobe.
// Modulus zero gives result zero.
// ---------------------------------------------------------------------------
module modular_exponentiation_top
    import mme_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MOD_BITS = MOD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [BASE_BITS-1:0] base,
    input  logic [EXP_FIELD-1:0] exponent,
    input  logic [MOD_FIELD-1:0] modulus,
    output logic                 done,
    output logic [MOD_FIELD-1:0] result
);

    localparam int SIDE_W = 1 + MOD_BITS + EXP_BITS;  // {zero, b, e}

    // ---------------- base reduction: one base bit per stage ----------------
    logic                 rv_reg [0:BASE_BITS];
    logic [MOD_BITS-1:0]  rr_reg [0:BASE_BITS];
    logic [BASE_BITS-1:0] rb_reg [0:BASE_BITS];
    logic [EXP_BITS-1:0]  re_reg [0:BASE_BITS];
    logic [MOD_BITS-1:0]  rm_reg [0:BASE_BITS];

    assign busy = 1'b0;

    // stage 0: input capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else
            rv_reg[0] <= start;
    end

    always_ff @(posedge clk)
    begin
        rr_reg[0] <= '0;
        rb_reg[0] <= base;
        re_reg[0] <= exponent[EXP_BITS-1:0];
        rm_reg[0] <= modulus[MOD_BITS-1:0];
    end

    genvar i;
    generate
        for (i = 1; i <= BASE_BITS; i++)
        begin : g_red
            logic [MOD_BITS:0]   shifted;
            logic [MOD_BITS-1:0] r_next;

            // r = (2r + bit) mod m; r < m so one subtract suffices
            always_comb
            begin
                shifted = {rr_reg[i-1], rb_reg[i-1][BASE_BITS-1]};
                if (shifted >= {1'b0, rm_reg[i-1]})
                    r_next = MOD_BITS'(shifted - {1'b0, rm_reg[i-1]});
                else
                    r_next = shifted[MOD_BITS-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    rv_reg[i] <= 1'b0;
                else
                    rv_reg[i] <= rv_reg[i-1];
            end

            always_ff @(posedge clk)
            begin
                rr_reg[i] <= r_next;
                rb_reg[i] <= {rb_reg[i-1][BASE_BITS-2:0], 1'b0};
                re_reg[i] <= re_reg[i-1];
                rm_reg[i] <= rm_reg[i-1];
            end
        end
    endgenerate

    // ---------------- exponent chain: square, then multiply -----------------
    logic                c_v    [0:EXP_BITS];
    logic [MOD_BITS-1:0] c_acc  [0:EXP_BITS];
    logic [MOD_BITS-1:0] c_m    [0:EXP_BITS];
    logic [SIDE_W-1:0]   c_side [0:EXP_BITS];

    logic red_m_zero;
    logic red_m_one;

    assign red_m_zero = (rm_reg[BASE_BITS] == '0);
    assign red_m_one  = (rm_reg[BASE_BITS] == MOD_BITS'(1));

    // accumulator starts at 1 mod m
    assign c_v[0]    = rv_reg[BASE_BITS];
    assign c_acc[0]  = (red_m_one || red_m_zero) ? '0 : MOD_BITS'(1);
    assign c_m[0]    = rm_reg[BASE_BITS];
    assign c_side[0] = {red_m_zero, rr_reg[BASE_BITS], re_reg[BASE_BITS]};

    genvar p;
    generate
        for (p = 0; p < EXP_BITS; p++)
        begin : g_bit
            logic                s_v;
            logic [MOD_BITS-1:0] s_acc;
            logic [MOD_BITS-1:0] s_m;
            logic [SIDE_W-1:0]   s_side;
            logic [MOD_BITS-1:0] mul_y;
            logic                e_bit;

            mme_modmul #(
                .MOD_BITS (MOD_BITS),
                .SIDE_W   (SIDE_W)
            ) u_sq (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (c_v[p]),
                .in_x      (c_acc[p]),
                .in_y      (c_acc[p]),
                .in_m      (c_m[p]),
                .in_side   (c_side[p]),
                .out_valid (s_v),
                .out_p     (s_acc),
                .out_m     (s_m),
                .out_side  (s_side)
            );

            // exponent scanned from its top bit down; a zero bit multiplies by 1
            assign e_bit = s_side[EXP_BITS-1-p];
            assign mul_y = e_bit ? s_side[EXP_BITS +: MOD_BITS] : MOD_BITS'(1);

            mme_modmul #(
                .MOD_BITS (MOD_BITS),
                .SIDE_W   (SIDE_W)
            ) u_mul (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (s_v),
                .in_x      (s_acc),
                .in_y      (mul_y),
                .in_m      (s_m),
                .in_side   (s_side),
                .out_valid (c_v[p+1]),
                .out_p     (c_acc[p+1]),
                .out_m     (c_m[p+1]),
                .out_side  (c_side[p+1])
            );
        end
    endgenerate

    // ---------------- output register ----------------
    logic                 done_reg;
    logic [MOD_FIELD-1:0] result_reg;
    logic [MOD_FIELD-1:0] result_next;

    assign result_next = c_side[EXP_BITS][SIDE_W-1] ? '0 : MOD_FIELD'(c_acc[EXP_BITS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c_v[EXP_BITS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* verif/modular_exponentiation_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_exponentiation_top_tb
// Self-checking bench for the modular exponentiation pipeline.
// ---------------------------------------------------------------------------
// A directed set of jobs covers the corner cases, then random jobs follow:
// exponent zero, modulus one and zero, all-ones fields, and bases that are
// multiples of the modulus. Each accepted transaction is run through a
// square-and-multiply predictor and queued. Each done strobe is compared
// with the oldest queued value. The sender idles at random and once drains
// the whole pipeline before going on.
// ---------------------------------------------------------------------------
module modular_exponentiation_top_tb
    import mme_pkg::*;
();

    localparam int PIPE_LAT = 1 + 64 + 2 * EXP_BITS_DEF * MOD_BITS_DEF + 1;
    localparam int N_RANDOM = 1400;

    // Expected-result store plus the predictor that fills it.
    class modexp_scoreboard;
        logic [MOD_FIELD-1:0] pending_q[$];
        int                   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Left-to-right square-and-multiply; 32-bit operands keep
        // every product exact in 64 bits.
        function logic [MOD_FIELD-1:0] pow_mod(logic [BASE_BITS-1:0] b,
                                               logic [EXP_FIELD-1:0] e,
                                               logic [MOD_FIELD-1:0] m);
            logic [63:0] acc;
            logic [63:0] red;
            logic [63:0] mm;
            logic [63:0] emask;
            logic [63:0] mmask;
            mmask = ~64'd0 >> (64 - MOD_BITS_DEF);
            emask = ~64'd0 >> (64 - EXP_BITS_DEF);
            mm = {32'd0, m} & mmask;
            e = e & emask;
            if (mm == 0)
                return '0;
            red = b % mm;
            acc = 64'd1;
            for (int pos = EXP_BITS_DEF - 1; pos >= 0; pos--)
            begin
                acc = (acc * acc) % mm;
                if (e[pos])
                    acc = (acc * red) % mm;
            end
            acc = acc % mm;
            return acc[MOD_FIELD-1:0];
        endfunction

        function void note_job(logic [BASE_BITS-1:0] b, logic [EXP_FIELD-1:0] e,
                               logic [MOD_FIELD-1:0] m);
            pending_q.push_back(pow_mod(b, e, m));
        endfunction

        function void check_result(logic [MOD_FIELD-1:0] got);
            logic [MOD_FIELD-1:0] want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: result %h with no job outstanding", got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: result mismatch, expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [BASE_BITS-1:0] base;
    logic [EXP_FIELD-1:0] exponent;
    logic [MOD_FIELD-1:0] modulus;
    logic                 done;
    logic [MOD_FIELD-1:0] result;

    modexp_scoreboard sb;

    modular_exponentiation_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .base     (base),
        .exponent (exponent),
        .modulus  (modulus),
        .done     (done),
        .result   (result)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Results cannot be held off, so every strobe is checked at the edge
    // that ends it; outputs are read before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(result);
    end

    // Present one transaction and hold it until the edge that takes it.
    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_job(logic [BASE_BITS-1:0] b, logic [EXP_FIELD-1:0] e,
                            logic [MOD_FIELD-1:0] m);
        start    <= 1'b1;
        base     <= b;
        exponent <= e;
        modulus  <= m;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_job(b, e, m);
    endtask

    // Idle gap: mostly none, sometimes short, rarely long.
    task automatic idle_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            n = 0;
        else if (pick < 92)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(10, 80);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Modulus mix: mostly full random, plus small, top-heavy and edge values.
    function automatic logic [MOD_FIELD-1:0] rand_mod();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom();
        else if (pick < 70)
            return $urandom_range(1, 64);
        else if (pick < 85)
            return 32'h8000_0000 | $urandom();
        else if (pick < 92)
            return 32'hFFFF_FFFF;
        else if (pick < 97)
            return 32'd1;
        else
            return 32'd0;
    endfunction

    function automatic logic [EXP_FIELD-1:0] rand_exp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return rand64();
        else if (pick < 85)
            return $urandom_range(0, 300);
        else if (pick < 95)
            return rand64() >> $urandom_range(1, 63);
        else
            return 64'd0;
    endfunction

    task automatic wait_drain();
        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [MOD_FIELD-1:0] m;
        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        base     = '0;
        exponent = '0;
        modulus  = 32'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: exponent zero, modulus one and zero, all-ones
        // fields, base zero, base a multiple of the modulus, exponent one.
        send_job(64'd5, 64'd0, 32'd1);
        send_job(64'd5, 64'd0, 32'd2);
        send_job(64'd0, 64'd0, 32'hFFFF_FFFF);
        send_job(64'd12345, 64'd999, 32'd1);
        send_job(64'd12345, 64'd999, 32'd0);
        send_job(~64'd0, ~64'd0, 32'hFFFF_FFFF);
        send_job(~64'd0, ~64'd0, 32'hFFFF_FFFB);
        send_job(64'd0, 64'd7, 32'd97);
        send_job(64'd0, 64'd0, 32'd97);
        send_job(64'd97 * 64'd1000003, 64'd3, 32'd97);
        send_job(64'd2, 64'd1, 32'd1000);
        send_job(64'd2, 64'd63, 32'h8000_0000);
        send_job(64'd3, 64'h8000_0000_0000_0000, 32'd1_000_000_007);
        send_job(~64'd0, 64'd1, 32'd2);
        send_job(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'h7FFF_FFFF);
        send_job(64'd4, 64'd13, 32'd497);
        idle_gap();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            m = rand_mod();
            case ($urandom_range(0, 9))
                0: send_job(rand64() % {32'd0, (m == 0) ? 32'd1 : m} * m, rand_exp(), m);
                1: send_job(~64'd0, rand_exp(), m);
                default: send_job(rand64(), rand_exp(), m);
            endcase
            // Drain the whole pipeline once, midway.
            if (i == N_RANDOM / 2)
                wait_drain();
            else
                idle_gap();
        end

        wait_drain();
        repeat (PIPE_LAT / 10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, sized well past the slowest run.
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
hdl/mme_pkg.sv
hdl/mme_modmul.sv
hdl/modular_exponentiation_top.sv
verif/modular_exponentiation_top_tb.sv
